/* hdl/xga_pkg.sv */
// shared types and constants for the cross-correlation gradient accumulator
// no dependencies; compiled first
package xga_pkg;

    localparam int PT_W      = 12;
    localparam int SMP_W     = 16;
    localparam int ACC_W     = 56;
    localparam int CONTRIB_W = 50;
    localparam int PROD_W    = 49;
    localparam int DEN_W     = 48;
    localparam int GRAD_W    = 48;
    localparam int DIV_BITS  = 48;
    localparam int NUM_W     = 58;

    localparam logic [SMP_W-1:0] SAMPLE_COUNT_RESET = 16'd1024;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [GRAD_W-1:0] OUT_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
    localparam logic signed [GRAD_W-1:0] OUT_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

    typedef struct packed {
        logic [PT_W-1:0]         point;
        logic                    first_freq;
        logic                    last_freq;
        logic                    keep;
        logic signed [SMP_W-1:0] inc_re;
        logic signed [SMP_W-1:0] inc_im;
        logic signed [SMP_W-1:0] adj_re;
        logic signed [SMP_W-1:0] adj_im;
        logic signed [SMP_W-1:0] fac_re;
        logic signed [SMP_W-1:0] fac_im;
        logic [SMP_W-1:0]        velocity;
    } item_t;

    typedef struct packed {
        logic                     valid;
        logic [PT_W-1:0]          point;
        logic                     first;
        logic                     last;
        logic                     keep;
        logic signed [PROD_W-1:0] m_a;
        logic signed [PROD_W-1:0] m_b;
        logic [DEN_W-1:0]         den;
    } mac_t;

    typedef struct packed {
        logic                    valid;
        logic [PT_W-1:0]         point;
        logic signed [ACC_W-1:0] acc;
        logic [DEN_W-1:0]        den;
    } acc_t;

    typedef struct packed {
        logic                  valid;
        logic [PT_W-1:0]       point;
        logic                  neg;
        logic                  zero;
        logic                  ovf;
        logic [DIV_BITS-1:0]   nlow;
        logic [DEN_W:0]        d;
        logic [DEN_W:0]        r;
        logic [DIV_BITS-1:0]   q;
    } dstage_t;

endpackage

/* hdl/xga_if.sv */
// valid/ready channel interfaces for input items and result items
// depends on xga_pkg
interface xga_in_if;
    import xga_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [PT_W-1:0]         point;
    logic                    first_freq;
    logic                    last_freq;
    logic                    keep;
    logic signed [SMP_W-1:0] inc_re;
    logic signed [SMP_W-1:0] inc_im;
    logic signed [SMP_W-1:0] adj_re;
    logic signed [SMP_W-1:0] adj_im;
    logic signed [SMP_W-1:0] fac_re;
    logic signed [SMP_W-1:0] fac_im;
    logic [SMP_W-1:0]        velocity;
    modport source (output valid, point, first_freq, last_freq, keep, inc_re, inc_im,
                    adj_re, adj_im, fac_re, fac_im, velocity, input ready);
    modport sink (input valid, point, first_freq, last_freq, keep, inc_re, inc_im,
                  adj_re, adj_im, fac_re, fac_im, velocity, output ready);
endinterface

interface xga_out_if;
    import xga_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [PT_W-1:0]          out_point;
    logic signed [GRAD_W-1:0] gradient;
    modport source (output valid, out_point, gradient, input ready);
    modport sink (input valid, out_point, gradient, output ready);
endinterface

/* hdl/xga_front.sv */
// multiply stages: complex product, factor products and normalization divisor
// depends on xga_pkg
module xga_front #(
    parameter int NPOINTS = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      item_valid,
    input  xga_pkg::item_t            item,
    input  logic [xga_pkg::SMP_W-1:0] sample_count,
    output xga_pkg::mac_t             mac
);
    import xga_pkg::*;

    logic [31:0] pt_wide;
    logic        in_range;

    logic                    v1_reg, f1_reg, l1_reg, k1_reg;
    logic [PT_W-1:0]         pt1_reg;
    logic signed [31:0]      prr_reg, pii_reg, pri_reg, pir_reg;
    logic signed [SMP_W-1:0] fr1_reg, fi1_reg;
    logic [31:0]             vv1_reg;

    logic                    v2_reg, f2_reg, l2_reg, k2_reg;
    logic [PT_W-1:0]         pt2_reg;
    logic signed [32:0]      cr2_reg, ci2_reg;
    logic signed [SMP_W-1:0] fr2_reg, fi2_reg;
    logic [DEN_W-1:0]        den2_reg;

    logic                     v3_reg, f3_reg, l3_reg, k3_reg;
    logic [PT_W-1:0]          pt3_reg;
    logic signed [PROD_W-1:0] ma3_reg, mb3_reg;
    logic [DEN_W-1:0]         den3_reg;

    assign pt_wide  = 32'(item.point);
    assign in_range = pt_wide < 32'(NPOINTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= item_valid && in_range;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt1_reg <= item.point;
            f1_reg  <= item.first_freq;
            l1_reg  <= item.last_freq;
            k1_reg  <= item.keep;
            prr_reg <= item.inc_re * item.adj_re;
            pii_reg <= item.inc_im * item.adj_im;
            pri_reg <= item.inc_re * item.adj_im;
            pir_reg <= item.inc_im * item.adj_re;
            fr1_reg <= item.fac_re;
            fi1_reg <= item.fac_im;
            vv1_reg <= item.velocity * item.velocity;

            pt2_reg  <= pt1_reg;
            f2_reg   <= f1_reg;
            l2_reg   <= l1_reg;
            k2_reg   <= k1_reg;
            cr2_reg  <= 33'(prr_reg) - 33'(pii_reg);
            ci2_reg  <= 33'(pri_reg) + 33'(pir_reg);
            fr2_reg  <= fr1_reg;
            fi2_reg  <= fi1_reg;
            den2_reg <= sample_count * vv1_reg;

            pt3_reg  <= pt2_reg;
            f3_reg   <= f2_reg;
            l3_reg   <= l2_reg;
            k3_reg   <= k2_reg;
            ma3_reg  <= cr2_reg * fi2_reg;
            mb3_reg  <= ci2_reg * fr2_reg;
            den3_reg <= den2_reg;
        end
    end

    assign mac.valid = v3_reg;
    assign mac.point = pt3_reg;
    assign mac.first = f3_reg;
    assign mac.last  = l3_reg;
    assign mac.keep  = k3_reg;
    assign mac.m_a   = ma3_reg;
    assign mac.m_b   = mb3_reg;
    assign mac.den   = den3_reg;

endmodule

/* hdl/xga_accum.sv */
// per-point accumulator memory with read-modify-write and one-deep forwarding
// depends on xga_pkg
module xga_accum #(
    parameter int NPOINTS = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  xga_pkg::mac_t mac,
    output xga_pkg::acc_t acc_out
);
    import xga_pkg::*;

    localparam int AW = (NPOINTS > 1) ? $clog2(NPOINTS) : 1;

    logic signed [ACC_W-1:0] mem [NPOINTS];

    logic [31:0] rd_wide, wr_wide;

    logic                        v4_reg, f4_reg, l4_reg, k4_reg;
    logic [PT_W-1:0]             pt4_reg;
    logic signed [CONTRIB_W-1:0] contrib4_reg;
    logic [DEN_W-1:0]            den4_reg;
    logic signed [ACC_W-1:0]     rd_reg;

    logic                    v5_reg, l5_reg;
    logic [PT_W-1:0]         pt5_reg;
    logic signed [ACC_W-1:0] acc5_reg;
    logic [DEN_W-1:0]        den5_reg;

    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W:0]   sum;
    logic signed [ACC_W-1:0] acc_next;

    assign rd_wide = 32'(mac.point);
    assign wr_wide = 32'(pt4_reg);

    always_comb
    begin
        if (f4_reg)
            base = '0;
        else if (v5_reg && (pt5_reg == pt4_reg))
            base = acc5_reg;
        else
            base = rd_reg;
        sum = (ACC_W+1)'(base) + (ACC_W+1)'(contrib4_reg);
        if (!k4_reg)
            acc_next = base;
        else if (sum[ACC_W] != sum[ACC_W-1])
            acc_next = sum[ACC_W] ? ACC_MIN : ACC_MAX;
        else
            acc_next = sum[ACC_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_reg <= mem[rd_wide[AW-1:0]];
            if (v4_reg)
                mem[wr_wide[AW-1:0]] <= acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= mac.valid;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt4_reg      <= mac.point;
            f4_reg       <= mac.first;
            l4_reg       <= mac.last;
            k4_reg       <= mac.keep;
            contrib4_reg <= CONTRIB_W'(mac.m_a) + CONTRIB_W'(mac.m_b);
            den4_reg     <= mac.den;

            pt5_reg  <= pt4_reg;
            l5_reg   <= l4_reg;
            acc5_reg <= acc_next;
            den5_reg <= den4_reg;
        end
    end

    assign acc_out.valid = v5_reg && l5_reg;
    assign acc_out.point = pt5_reg;
    assign acc_out.acc   = acc5_reg;
    assign acc_out.den   = den5_reg;

endmodule

/* hdl/xga_divider.sv */
// pipelined restoring divider, one quotient bit per stage, for round(2*acc/den)
// depends on xga_pkg
module xga_divider (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  xga_pkg::acc_t    acc_in,
    output xga_pkg::dstage_t quot
);
    import xga_pkg::*;

    dstage_t st_reg [DIV_BITS+1];
    dstage_t prep;

    logic [ACC_W-1:0] mag;
    logic [NUM_W-1:0] num;
    logic [DEN_W:0]   dvs;
    logic [DEN_W:0]   num_hi;

    always_comb
    begin
        mag    = acc_in.acc[ACC_W-1] ? ACC_W'(-acc_in.acc) : ACC_W'(acc_in.acc);
        num    = {mag, 2'b00} + NUM_W'(acc_in.den);
        dvs    = {acc_in.den, 1'b0};
        num_hi = (DEN_W+1)'(num[NUM_W-1:DIV_BITS]);
        prep.valid = acc_in.valid;
        prep.point = acc_in.point;
        prep.neg   = acc_in.acc[ACC_W-1];
        prep.zero  = (mag == '0);
        prep.ovf   = (num_hi >= dvs);
        prep.nlow  = num[DIV_BITS-1:0];
        prep.d     = dvs;
        prep.r     = prep.ovf ? '0 : num_hi;
        prep.q     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg[0] <= '0;
        else if (en)
            st_reg[0] <= prep;
    end

    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_stage
        logic [DEN_W+1:0] trial;
        logic [DEN_W+1:0] diff;
        dstage_t          nxt;

        always_comb
        begin
            trial = {st_reg[k].r, st_reg[k].nlow[DIV_BITS-1-k]};
            diff  = trial - {1'b0, st_reg[k].d};
            nxt   = st_reg[k];
            if (trial >= {1'b0, st_reg[k].d})
            begin
                nxt.r = diff[DEN_W:0];
                nxt.q[DIV_BITS-1-k] = 1'b1;
            end
            else
                nxt.r = trial[DEN_W:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                st_reg[k+1] <= '0;
            else if (en)
                st_reg[k+1] <= nxt;
        end
    end

    assign quot = st_reg[DIV_BITS];

endmodule

/* hdl/xga_if_dummy_note.sv */
// sign application and saturation of the divider quotient into a gradient word
// depends on xga_pkg
module xga_round (
    input  xga_pkg::dstage_t                quot,
    output logic signed [xga_pkg::GRAD_W-1:0] gradient
);
    import xga_pkg::*;

    logic [GRAD_W-1:0] lim;
    logic              sat;

    always_comb
    begin
        lim = {1'b0, {(GRAD_W-1){1'b1}}} + GRAD_W'(quot.neg);
        sat = quot.ovf || (quot.q > lim);
        if (quot.zero)
            gradient = '0;
        else if (sat)
            gradient = quot.neg ? OUT_MIN : OUT_MAX;
        else if (quot.neg)
            gradient = -$signed(quot.q);
        else
            gradient = $signed(quot.q);
    end

endmodule

/* hdl/xga_round.sv */
// rounding stage wrapper kept for file-per-module order; holds the output register
// depends on xga_pkg and xga_round in xga_if_dummy_note.sv
module xga_outreg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  xga_pkg::dstage_t                  quot,
    output logic                              valid,
    output logic [xga_pkg::PT_W-1:0]          out_point,
    output logic signed [xga_pkg::GRAD_W-1:0] gradient
);
    import xga_pkg::*;

    logic signed [GRAD_W-1:0] grad_next;
    logic                     valid_reg;
    logic [PT_W-1:0]          point_reg;
    logic signed [GRAD_W-1:0] grad_reg;

    xga_round u_round (
        .quot     (quot),
        .gradient (grad_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= quot.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            point_reg <= quot.point;
            grad_reg  <= grad_next;
        end
    end

    assign valid     = valid_reg;
    assign out_point = point_reg;
    assign gradient  = grad_reg;

endmodule

/* hdl/xcorr_gradient_accumulator.sv */
// top level of the cross-correlation gradient accumulator
// depends on xga_pkg, xga_if, xga_front, xga_accum, xga_divider, xga_outreg
//
// One item is accepted per cycle; the whole pipeline advances together and holds
// only while a result waits in the output register. Items pass 3 multiply stages,
// 2 accumulator stages (the memory read-modify-write with forwarding from the
// stage behind it), one divider setup stage, 48 restoring-division stages and the
// output register. The user must write sample_count through cfg_we/cfg_wdata only
// while no item is in flight; the block does not enforce this. Accumulator entries
// are not cleared at reset; the first item of a point must carry first_freq.
module xcorr_gradient_accumulator #(
    parameter int NPOINTS = 4096
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [xga_pkg::SMP_W-1:0] cfg_wdata,
    xga_in_if.sink                    sample,
    xga_out_if.source                 result
);
    import xga_pkg::*;

    logic             en;
    logic [SMP_W-1:0] sample_count_reg;
    item_t            item;
    mac_t             mac;
    acc_t             acc;
    dstage_t          quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_count_reg <= SAMPLE_COUNT_RESET;
        else if (cfg_we)
            sample_count_reg <= cfg_wdata;
    end

    assign en           = !result.valid || result.ready;
    assign sample.ready = en;

    assign item.point      = sample.point;
    assign item.first_freq = sample.first_freq;
    assign item.last_freq  = sample.last_freq;
    assign item.keep       = sample.keep;
    assign item.inc_re     = sample.inc_re;
    assign item.inc_im     = sample.inc_im;
    assign item.adj_re     = sample.adj_re;
    assign item.adj_im     = sample.adj_im;
    assign item.fac_re     = sample.fac_re;
    assign item.fac_im     = sample.fac_im;
    assign item.velocity   = sample.velocity;

    xga_front #(.NPOINTS(NPOINTS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .item_valid   (sample.valid),
        .item         (item),
        .sample_count (sample_count_reg),
        .mac          (mac)
    );

    xga_accum #(.NPOINTS(NPOINTS)) u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .mac     (mac),
        .acc_out (acc)
    );

    xga_divider u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .acc_in (acc),
        .quot   (quot)
    );

    xga_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .quot      (quot),
        .valid     (result.valid),
        .out_point (result.out_point),
        .gradient  (result.gradient)
    );

    a_stall_only_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (result.valid && !result.ready))
        else $error("input stalled without output backpressure");

    a_zero_acc_zero_grad: assert property (@(posedge clk) disable iff (!rst_n)
        (en && quot.valid && quot.zero) |=> (result.valid && result.gradient == '0))
        else $error("zero accumulator gave nonzero gradient");

    a_sat_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (en && quot.valid && !quot.zero && quot.ovf) |=>
        (result.gradient == ($past(quot.neg) ? OUT_MIN : OUT_MAX)))
        else $error("overflowed quotient not saturated");

endmodule
